// ----- rtl/rto_est_pkg.sv -----
`default_nettype none

package rto_est_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_TICK_TIME       = 2'd0,
        CFG_MIN_RTO         = 2'd1,
        CFG_MAX_RTO         = 2'd2,
        CFG_MAX_RETRANSMITS = 2'd3
    } cfg_index_t;

    localparam int TICK_W     = 20;
    localparam int RTO_W      = 32;
    localparam int COUNT_W    = 8;
    localparam int SAMPLE_W   = 16;
    localparam int BACKOFF_W  = 3;
    localparam int BK_IDX_W   = 4;

    localparam logic [TICK_W-1:0]  TICK_TIME_RESET       = 20'd500;
    localparam logic [RTO_W-1:0]   MIN_RTO_RESET         = 32'd1000;
    localparam logic [RTO_W-1:0]   MAX_RTO_RESET         = 32'd64000;
    localparam logic [COUNT_W-1:0] MAX_RETRANSMITS_RESET = 8'd12;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;
    localparam logic [RTO_W-1:0]   EST_MAX     = 32'hFFFF_FFFF;
    localparam logic [RTO_W-1:0]   EST_FLOOR   = 32'd1;
    // The fold starts once the count passes a quarter of the limit.
    localparam int                 FOLD_DIV_SHIFT = 2;

    typedef struct packed {
        logic                operation;
        logic [SAMPLE_W-1:0] rtt_sample;
    } in_item_t;

    typedef struct packed {
        logic [RTO_W-1:0]   rto;
        logic               resend;
        logic               give_up;
        logic [COUNT_W-1:0] retries;
    } out_item_t;

    // Backoff factors are powers of two, so the table holds their exponents.
    function automatic logic [BACKOFF_W-1:0] backoff_log(input logic [BK_IDX_W-1:0] idx);
        logic [BACKOFF_W-1:0] lg;
        case (idx)
            4'd0:    lg = 3'd0;
            4'd1:    lg = 3'd1;
            4'd2:    lg = 3'd2;
            4'd3:    lg = 3'd3;
            4'd4:    lg = 3'd4;
            4'd5:    lg = 3'd5;
            default: lg = 3'd6;
        endcase
        return lg;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tcp_retransmit_timeout_estimator.sv -----
// Throughput: one item per cycle while out_stall is low; the estimator state is
// updated in the cycle of the input transfer, and the timeout goes through the
// A, B, C and output registers: snapshot, add, multiply and clamp stages.
// The 20 x 33 bit multiply by tick_time sets the length of the critical stage.
// Reset clears the estimator state and the pipeline and loads the default
// configuration; the block takes items in the first cycle after reset.
`default_nettype none

module tcp_retransmit_timeout_estimator
    import rto_est_pkg::*;
#(
    parameter int SRTT_SHIFT  = 3,
    parameter int VAR_SHIFT   = 2,
    parameter int BACKOFF_CAP = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [RTO_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data
);

    localparam int CALC_W = RTO_W + 2;
    localparam int BASE_W = RTO_W + 1;
    localparam int PROD_W = TICK_W + BASE_W;
    localparam int SHL_W  = PROD_W + 6;

    logic [TICK_W-1:0]  tick_time_reg;
    logic [RTO_W-1:0]   min_rto_reg;
    logic [RTO_W-1:0]   max_rto_reg;
    logic [COUNT_W-1:0] max_retransmits_reg;

    logic [RTO_W-1:0]   smoothed_rtt_reg, smoothed_rtt_next;
    logic [RTO_W-1:0]   rtt_variance_reg, rtt_variance_next;
    logic [COUNT_W-1:0] retransmit_count_reg, retransmit_count_next;

    // Stage A: estimator snapshot used for the timeout.
    logic                 a_valid_reg;
    logic [RTO_W-1:0]     a_srtt_reg, a_srtt_next;
    logic [RTO_W-1:0]     a_var_reg, a_var_next;
    logic [BACKOFF_W-1:0] a_log_reg, a_log_next;
    logic                 a_resend_reg, a_resend_next;
    logic                 a_give_up_reg, a_give_up_next;
    // Stage B: base sum.
    logic                 b_valid_reg;
    logic [BASE_W-1:0]    b_base_reg;
    logic [BACKOFF_W-1:0] b_log_reg;
    logic                 b_resend_reg;
    logic                 b_give_up_reg;
    logic [COUNT_W-1:0]   b_retries_reg;
    // Stage C: product with the tick period.
    logic                 c_valid_reg;
    logic [PROD_W-1:0]    c_prod_reg;
    logic [BACKOFF_W-1:0] c_log_reg;
    logic                 c_resend_reg;
    logic                 c_give_up_reg;
    logic [COUNT_W-1:0]   c_retries_reg;
    logic [COUNT_W-1:0]   a_retries_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic o_load, c_load, b_load, a_load, accept;

    assign o_load   = !out_valid_reg || !out_stall;
    assign c_load   = !c_valid_reg || o_load;
    assign b_load   = !b_valid_reg || c_load;
    assign a_load   = !a_valid_reg || b_load;
    assign in_stall = !a_load;
    assign accept   = in_valid && a_load;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Estimator update, done at the input transfer so the next item sees it.
    always_comb
    begin
        logic [CALC_W-1:0]   srtt_calc;
        logic [CALC_W-1:0]   delta;
        logic [CALC_W-1:0]   abs_delta;
        logic [CALC_W-1:0]   var_calc;
        logic [SAMPLE_W:0]   sample_inc;
        logic [BASE_W-1:0]   fold_sum;
        logic [COUNT_W-1:0]  count_inc;
        logic [COUNT_W-1:0]  bk_idx;
        logic [RTO_W-1:0]    srtt_sh;

        smoothed_rtt_next     = smoothed_rtt_reg;
        rtt_variance_next     = rtt_variance_reg;
        retransmit_count_next = retransmit_count_reg;
        a_resend_next         = 1'b0;
        a_give_up_next        = 1'b0;
        a_log_next            = '0;

        srtt_sh    = smoothed_rtt_reg >> SRTT_SHIFT;
        sample_inc = {1'b0, in_data.rtt_sample} + {{SAMPLE_W{1'b0}}, 1'b1};
        srtt_calc  = CALC_W'(smoothed_rtt_reg) - CALC_W'(srtt_sh)
                     + CALC_W'(in_data.rtt_sample);
        delta      = CALC_W'(in_data.rtt_sample) - CALC_W'(srtt_sh);
        abs_delta  = delta[CALC_W-1] ? (~delta + CALC_W'(1)) : delta;
        var_calc   = CALC_W'(rtt_variance_reg) - CALC_W'(rtt_variance_reg >> VAR_SHIFT)
                     + abs_delta;
        fold_sum   = BASE_W'(rtt_variance_reg) + BASE_W'(srtt_sh);
        count_inc  = (retransmit_count_reg == COUNT_MAX) ? COUNT_MAX
                     : retransmit_count_reg + COUNT_W'(1);
        bk_idx     = (count_inc < COUNT_W'(BACKOFF_CAP)) ? count_inc : COUNT_W'(BACKOFF_CAP);

        if (!in_data.operation)
        begin
            if (smoothed_rtt_reg != '0)
            begin
                if (srtt_calc == '0)
                    smoothed_rtt_next = EST_FLOOR;
                else if (srtt_calc > CALC_W'(EST_MAX))
                    smoothed_rtt_next = EST_MAX;
                else
                    smoothed_rtt_next = srtt_calc[RTO_W-1:0];
                if (var_calc == '0)
                    rtt_variance_next = EST_FLOOR;
                else if (var_calc > CALC_W'(EST_MAX))
                    rtt_variance_next = EST_MAX;
                else
                    rtt_variance_next = var_calc[RTO_W-1:0];
            end
            else
            begin
                smoothed_rtt_next = RTO_W'(sample_inc) << SRTT_SHIFT;
                rtt_variance_next = RTO_W'(sample_inc) << (VAR_SHIFT - 1);
            end
            retransmit_count_next = '0;
            // A sample reports the updated estimator.
            a_srtt_next = smoothed_rtt_next >> SRTT_SHIFT;
            a_var_next  = rtt_variance_next;
        end
        else
        begin
            retransmit_count_next = count_inc;
            a_log_next  = backoff_log(bk_idx[BK_IDX_W-1:0]);
            // A timeout reports the estimator as it was before any fold.
            a_srtt_next = srtt_sh;
            a_var_next  = rtt_variance_reg;
            if (count_inc <= max_retransmits_reg)
            begin
                a_resend_next = 1'b1;
                if (count_inc > (max_retransmits_reg >> FOLD_DIV_SHIFT))
                begin
                    rtt_variance_next = fold_sum[RTO_W] ? EST_MAX : fold_sum[RTO_W-1:0];
                    smoothed_rtt_next = '0;
                end
            end
            else
            begin
                a_give_up_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [SHL_W-1:0] scaled;
        logic [SHL_W-1:0] upper;

        scaled = SHL_W'(c_prod_reg) << c_log_reg;
        upper  = (scaled > SHL_W'(max_rto_reg)) ? SHL_W'(max_rto_reg) : scaled;
        if (upper < SHL_W'(min_rto_reg))
            out_data_next.rto = min_rto_reg;
        else
            out_data_next.rto = upper[RTO_W-1:0];
        out_data_next.resend  = c_resend_reg;
        out_data_next.give_up = c_give_up_reg;
        out_data_next.retries = c_retries_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg        <= TICK_TIME_RESET;
            min_rto_reg          <= MIN_RTO_RESET;
            max_rto_reg          <= MAX_RTO_RESET;
            max_retransmits_reg  <= MAX_RETRANSMITS_RESET;
            smoothed_rtt_reg     <= '0;
            rtt_variance_reg     <= '0;
            retransmit_count_reg <= '0;
            a_valid_reg          <= 1'b0;
            b_valid_reg          <= 1'b0;
            c_valid_reg          <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TICK_TIME:       tick_time_reg       <= cfg_data[TICK_W-1:0];
                    CFG_MIN_RTO:         min_rto_reg         <= cfg_data;
                    CFG_MAX_RTO:         max_rto_reg         <= cfg_data;
                    CFG_MAX_RETRANSMITS: max_retransmits_reg <= cfg_data[COUNT_W-1:0];
                    default:             tick_time_reg       <= tick_time_reg;
                endcase
            end
            if (accept)
            begin
                smoothed_rtt_reg     <= smoothed_rtt_next;
                rtt_variance_reg     <= rtt_variance_next;
                retransmit_count_reg <= retransmit_count_next;
            end
            if (a_load)
                a_valid_reg <= accept;
            if (b_load)
                b_valid_reg <= a_valid_reg;
            if (c_load)
                c_valid_reg <= b_valid_reg;
            if (o_load)
                out_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_srtt_reg    <= a_srtt_next;
            a_var_reg     <= a_var_next;
            a_log_reg     <= a_log_next;
            a_resend_reg  <= a_resend_next;
            a_give_up_reg <= a_give_up_next;
            a_retries_reg <= retransmit_count_next;
        end
        if (b_load)
        begin
            b_base_reg    <= BASE_W'(a_srtt_reg) + BASE_W'(a_var_reg);
            b_log_reg     <= a_log_reg;
            b_resend_reg  <= a_resend_reg;
            b_give_up_reg <= a_give_up_reg;
            b_retries_reg <= a_retries_reg;
        end
        if (c_load)
        begin
            c_prod_reg    <= PROD_W'(tick_time_reg) * PROD_W'(b_base_reg);
            c_log_reg     <= b_log_reg;
            c_resend_reg  <= b_resend_reg;
            c_give_up_reg <= b_give_up_reg;
            c_retries_reg <= b_retries_reg;
        end
        if (o_load)
            out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // With the output free, every stage can move, so the input never stalls.
    assert property (@(posedge clk) disable iff (!rst_n) !out_stall |-> !in_stall)
        else $error("input stalled while the output was free");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_data.operation |=> retransmit_count_reg == '0 && smoothed_rtt_reg != '0)
        else $error("sample did not clear the count or left a zero estimate");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.resend |-> !out_data.give_up && out_data.retries != '0)
        else $error("resend result with give-up or zero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.operation && retransmit_count_reg != COUNT_MAX
        |=> retransmit_count_reg == $past(retransmit_count_reg) + COUNT_W'(1))
        else $error("timeout did not advance the count");
`endif

endmodule

`default_nettype wire
